>>> rtl/core/adc_round_robin_sequencer_macros.svh
// Assertion macros for the round-robin ADC sequencer.
// Each macro is fully compiled for simulation and empty for synthesis.
`ifndef ADC_ROUND_ROBIN_SEQUENCER_MACROS_SVH
`define ADC_ROUND_ROBIN_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define ARRS_ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ARRS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ARRS_ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg)
`define ARRS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/core/arrs_pkg.sv
package arrs_pkg;

	localparam int EVT_BITS     = 3;
	localparam int IDX_BITS     = 3;
	localparam int MODE_BITS    = 2;
	localparam int CHAN_BITS    = 4;
	localparam int TRIG_BITS    = 3;
	localparam int STATE_BITS   = 2;
	localparam int MASK_BITS    = 6;
	localparam int REG_IDX_BITS = 2;

	// Highest channel number that maps onto a digital pin.
	localparam int MAX_DIGITAL_PIN = 5;

	// Event codes
	localparam logic [EVT_BITS-1:0] EV_START = 3'd0;
	localparam logic [EVT_BITS-1:0] EV_STOP  = 3'd1;
	localparam logic [EVT_BITS-1:0] EV_DONE  = 3'd2;
	localparam logic [EVT_BITS-1:0] EV_CMP_A = 3'd3;
	localparam logic [EVT_BITS-1:0] EV_CMP_B = 3'd4;
	localparam logic [EVT_BITS-1:0] EV_REQ   = 3'd5;
	localparam logic [EVT_BITS-1:0] EV_READ  = 3'd6;

	// Entry measurement modes
	localparam logic [MODE_BITS-1:0] MODE_CONT    = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_ONESHOT = 2'd2;

	// Entry trigger modes
	localparam logic [TRIG_BITS-1:0] TRIG_IMMEDIATE = 3'd0;
	localparam logic [TRIG_BITS-1:0] TRIG_HW_FIRST  = 3'd1;
	localparam logic [TRIG_BITS-1:0] TRIG_HW_LAST   = 3'd5;
	localparam logic [TRIG_BITS-1:0] TRIG_CMP_A     = 3'd6;
	localparam logic [TRIG_BITS-1:0] TRIG_CMP_B     = 3'd7;

	// Sequencer run states
	localparam logic [STATE_BITS-1:0] RS_STOPPED  = 2'd0;
	localparam logic [STATE_BITS-1:0] RS_PENDING  = 2'd1;
	localparam logic [STATE_BITS-1:0] RS_STARTED  = 2'd2;
	localparam logic [STATE_BITS-1:0] RS_COMPLETE = 2'd3;

	// Configuration register indexes
	localparam logic [REG_IDX_BITS-1:0] REG_MODES    = 2'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_CHANNELS = 2'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_TRIGGERS = 2'd2;

	typedef struct packed {
		logic capture;
		logic execute;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_stall;
	} dp_stat_t;

endpackage

>>> rtl/core/arrs_evt_if.sv
interface arrs_evt_if
	import arrs_pkg::*;
#(
	parameter int SAMPLE_BITS = 10
) ();

	logic                   valid;
	logic                   ready;
	logic [EVT_BITS-1:0]    mode;
	logic [SAMPLE_BITS-1:0] sample;
	logic [IDX_BITS-1:0]    entry_index;

	modport source (output valid, output mode, output sample, output entry_index, input ready);
	modport sink (input valid, input mode, input sample, input entry_index, output ready);

endinterface

>>> rtl/core/arrs_res_if.sv
interface arrs_res_if
	import arrs_pkg::*;
#(
	parameter int SAMPLE_BITS = 10,
	parameter int COUNT_BITS  = 16
) ();

	logic                   valid;
	logic                   ready;
	logic                   start_now;
	logic                   auto_trigger_enable;
	logic [TRIG_BITS-1:0]   trigger_source;
	logic                   arm_compare_a;
	logic                   arm_compare_b;
	logic [CHAN_BITS-1:0]   channel_select;
	logic [STATE_BITS-1:0]  sequencer_state;
	logic [IDX_BITS-1:0]    current_entry;
	logic [COUNT_BITS-1:0]  conversions_done;
	logic [COUNT_BITS-1:0]  rounds_done;
	logic [MASK_BITS-1:0]   digital_disable_mask;
	logic [SAMPLE_BITS-1:0] read_value;

	modport source (
		output valid, output start_now, output auto_trigger_enable, output trigger_source,
		output arm_compare_a, output arm_compare_b, output channel_select,
		output sequencer_state, output current_entry, output conversions_done,
		output rounds_done, output digital_disable_mask, output read_value,
		input ready
	);
	modport sink (
		input valid, input start_now, input auto_trigger_enable, input trigger_source,
		input arm_compare_a, input arm_compare_b, input channel_select,
		input sequencer_state, input current_entry, input conversions_done,
		input rounds_done, input digital_disable_mask, input read_value,
		output ready
	);

endinterface

>>> rtl/core/arrs_ctrl.sv
module arrs_ctrl
	import arrs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      evt_valid,
	output logic      evt_ready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d     = state_q;
		evt_ready   = 1'b0;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		case (state_q)
			S_IDLE: begin
				evt_ready   = 1'b1;
				cmd.capture = evt_valid;
				if (evt_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				// Wait here while the previous result has not been taken.
				if (!stat.out_stall) begin
					cmd.execute = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/core/arrs_datapath.sv
module arrs_datapath
	import arrs_pkg::*;
#(
	parameter int NUM_ENTRIES = 5,
	parameter int SAMPLE_BITS = 10,
	parameter int COUNT_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [REG_IDX_BITS-1:0]       cfg_index,
	input  logic [CHAN_BITS*NUM_ENTRIES-1:0] cfg_data,
	input  logic [EVT_BITS-1:0]           evt_mode,
	input  logic [SAMPLE_BITS-1:0]        evt_sample,
	input  logic [IDX_BITS-1:0]           evt_entry_index,
	input  ctrl_cmd_t                     cmd,
	output dp_stat_t                      stat,
	arrs_res_if.source                    res
);

	localparam int PW = $clog2(NUM_ENTRIES);
	localparam int CW = PW + 1;

	// Configuration
	logic [MODE_BITS*NUM_ENTRIES-1:0] modes_q;
	logic [CHAN_BITS*NUM_ENTRIES-1:0] chans_q;
	logic [TRIG_BITS*NUM_ENTRIES-1:0] trigs_q;

	// Captured event
	logic [EVT_BITS-1:0]    mode_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic [IDX_BITS-1:0]    idx_q;

	// Sequencer state
	logic [PW-1:0]          pos_q;
	logic [STATE_BITS-1:0]  run_q;
	logic [NUM_ENTRIES-1:0] req_q;
	logic [SAMPLE_BITS-1:0] samples_q [NUM_ENTRIES];
	logic [COUNT_BITS-1:0]  conv_q;
	logic [COUNT_BITS-1:0]  round_q;
	logic [1:0]             cmp_q;
	logic [MASK_BITS-1:0]   mask_q;

	// Result register
	logic                   res_valid_q;
	logic                   start_now_q;
	logic                   ate_q;
	logic [TRIG_BITS-1:0]   tsrc_q;
	logic [CHAN_BITS-1:0]   chan_sel_q;
	logic [SAMPLE_BITS-1:0] read_value_q;

	logic [MODE_BITS-1:0] mode_a [NUM_ENTRIES];
	logic [CHAN_BITS-1:0] chan_a [NUM_ENTRIES];
	logic [TRIG_BITS-1:0] trig_a [NUM_ENTRIES];

	logic                   done_ok;
	logic                   idx_ok;
	logic                   search_en;
	logic [NUM_ENTRIES-1:0] req_search;
	logic [NUM_ENTRIES-1:0] elig;
	logic                   found;
	logic [PW-1:0]          found_pos;
	logic                   wrap;
	logic [CW-1:0]          cand_wide;
	logic [PW-1:0]          cand;
	logic [MASK_BITS-1:0]   new_mask;

	logic [PW-1:0]          pos_d;
	logic [TRIG_BITS-1:0]   t_d;
	logic [STATE_BITS-1:0]  run_d;
	logic [NUM_ENTRIES-1:0] req_d;
	logic [COUNT_BITS-1:0]  conv_d;
	logic [COUNT_BITS-1:0]  round_d;
	logic [COUNT_BITS-1:0]  round_base;
	logic [1:0]             cmp_d;
	logic [MASK_BITS-1:0]   mask_d;
	logic                   pulse;
	logic [SAMPLE_BITS-1:0] rv;
	logic                   smp_we;
	logic                   ate;

	always_comb begin
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			mode_a[i] = modes_q[MODE_BITS*i +: MODE_BITS];
			chan_a[i] = chans_q[CHAN_BITS*i +: CHAN_BITS];
			trig_a[i] = trigs_q[TRIG_BITS*i +: TRIG_BITS];
		end
	end

	assign done_ok = (run_q == RS_STARTED) || (run_q == RS_PENDING && cmp_q == 2'b00);
	assign idx_ok  = {1'b0, idx_q} < (IDX_BITS + 1)'(NUM_ENTRIES);
	assign search_en = (mode_q == EV_START) || (mode_q == EV_DONE && done_ok);

	// The finished entry's request is dropped before the search looks at it.
	assign req_search = (mode_q == EV_DONE) ? (req_q & ~(NUM_ENTRIES'(1) << pos_q)) : req_q;

	always_comb begin
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			elig[i] = (mode_a[i] == MODE_CONT) || (mode_a[i] == MODE_ONESHOT && req_search[i]);
		end
	end

	// Rotating priority search: candidates pos+1 .. pos+N, nearest one wins.
	always_comb begin
		found     = 1'b0;
		found_pos = pos_q;
		cand_wide = '0;
		cand      = '0;
		for (int k = NUM_ENTRIES; k >= 1; k--) begin
			cand_wide = CW'(pos_q) + CW'(k);
			if (cand_wide >= CW'(NUM_ENTRIES)) begin
				cand_wide = cand_wide - CW'(NUM_ENTRIES);
			end
			cand = cand_wide[PW-1:0];
			if (elig[cand]) begin
				found     = 1'b1;
				found_pos = cand;
			end
		end
	end

	// A full circle with no hit also passes the last entry once.
	assign wrap = !found || (found_pos <= pos_q);

	always_comb begin
		new_mask = '0;
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			if (chan_a[i] <= CHAN_BITS'(MAX_DIGITAL_PIN)) begin
				new_mask[chan_a[i][2:0]] = 1'b1;
			end
		end
	end

	assign pos_d = (search_en && found) ? found_pos : pos_q;
	assign t_d   = trig_a[pos_d];

	always_comb begin
		run_d      = run_q;
		req_d      = req_q;
		conv_d     = conv_q;
		round_base = round_q;
		round_d    = round_q;
		cmp_d      = cmp_q;
		mask_d     = mask_q;
		pulse      = 1'b0;
		rv         = '0;
		smp_we     = 1'b0;
		case (mode_q)
			EV_START: begin
				conv_d     = '0;
				round_base = '0;
				round_d    = '0;
				cmp_d      = 2'b00;
				mask_d     = new_mask;
			end
			EV_STOP: begin
				run_d = RS_STOPPED;
				cmp_d = 2'b00;
			end
			EV_DONE: begin
				if (done_ok) begin
					conv_d = conv_q + COUNT_BITS'(1);
					smp_we = 1'b1;
					req_d  = req_search;
					rv     = sample_q;
				end
			end
			EV_CMP_A: begin
				if (cmp_q[0]) begin
					cmp_d = 2'b00;
					run_d = RS_STARTED;
					pulse = 1'b1;
				end
			end
			EV_CMP_B: begin
				if (cmp_q[1]) begin
					cmp_d = 2'b00;
					run_d = RS_STARTED;
					pulse = 1'b1;
				end
			end
			EV_REQ: begin
				if (idx_ok) begin
					req_d = req_q | (NUM_ENTRIES'(1) << idx_q[PW-1:0]);
				end
			end
			EV_READ: begin
				if (idx_ok) begin
					rv = samples_q[idx_q[PW-1:0]];
				end
			end
			default: begin
			end
		endcase

		if (search_en) begin
			round_d = round_base + COUNT_BITS'(wrap);
			if (found) begin
				case (t_d)
					TRIG_IMMEDIATE: begin
						run_d = RS_STARTED;
						cmp_d = 2'b00;
						pulse = 1'b1;
					end
					TRIG_CMP_A: begin
						run_d = RS_PENDING;
						cmp_d = 2'b01;
					end
					TRIG_CMP_B: begin
						run_d = RS_PENDING;
						cmp_d = 2'b10;
					end
					default: begin
						run_d = RS_PENDING;
						cmp_d = 2'b00;
					end
				endcase
			end else begin
				run_d = RS_STOPPED;
			end
		end
	end

	assign ate = (run_d == RS_PENDING) && (t_d inside {[TRIG_HW_FIRST:TRIG_HW_LAST]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modes_q <= '0;
			chans_q <= '0;
			trigs_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODES:    modes_q <= cfg_data[MODE_BITS*NUM_ENTRIES-1:0];
				REG_CHANNELS: chans_q <= cfg_data[CHAN_BITS*NUM_ENTRIES-1:0];
				REG_TRIGGERS: trigs_q <= cfg_data[TRIG_BITS*NUM_ENTRIES-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q   <= evt_mode;
			sample_q <= evt_sample;
			idx_q    <= evt_entry_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			run_q   <= RS_STOPPED;
			req_q   <= '0;
			conv_q  <= '0;
			round_q <= '0;
			cmp_q   <= 2'b00;
			mask_q  <= '0;
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				samples_q[i] <= '0;
			end
		end else if (cmd.execute) begin
			pos_q   <= pos_d;
			run_q   <= run_d;
			req_q   <= req_d;
			conv_q  <= conv_d;
			round_q <= round_d;
			cmp_q   <= cmp_d;
			mask_q  <= mask_d;
			if (smp_we) begin
				samples_q[pos_q] <= sample_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.execute) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			start_now_q  <= pulse;
			ate_q        <= ate;
			tsrc_q       <= ate ? (t_d - TRIG_HW_FIRST) : '0;
			chan_sel_q   <= chan_a[pos_d];
			read_value_q <= rv;
		end
	end

	assign stat.out_stall = res_valid_q && !res.ready;

	// Sequencer state registers only change on execute, so they mirror the result.
	assign res.valid                = res_valid_q;
	assign res.start_now            = start_now_q;
	assign res.auto_trigger_enable  = ate_q;
	assign res.trigger_source       = tsrc_q;
	assign res.arm_compare_a        = cmp_q[0];
	assign res.arm_compare_b        = cmp_q[1];
	assign res.channel_select       = chan_sel_q;
	assign res.sequencer_state      = run_q;
	assign res.current_entry        = IDX_BITS'(pos_q);
	assign res.conversions_done     = conv_q;
	assign res.rounds_done          = round_q;
	assign res.digital_disable_mask = mask_q;
	assign res.read_value           = read_value_q;

endmodule

>>> rtl/core/adc_round_robin_sequencer.sv
// Round-robin ADC conversion sequencer.
// Events (start, stop, conversion done, compare A/B, one-shot request, read)
// arrive on the evt channel; every event produces exactly one transaction on
// the res channel with the sequencer outputs after that event.
// Entry modes, channels and triggers are written through cfg_we, cfg_index
// and cfg_data; the user must do so only while no event is in flight, which the block itself does not enforce.
// An accepted event is captured, then executed once the result register is
// free; its result is valid from then until it is taken. No new event is
// accepted until the captured one has executed, which runs the rotating
// priority search over all entries and updates the state.
// While the receiver stalls, the result holds and one more event is
// captured; that event waits until the result register has been taken.
// Reset clears the configuration, counters, requests, stored samples and the
// result valid flag; the sequencer comes up stopped at entry zero.
module adc_round_robin_sequencer
	import arrs_pkg::*;
#(
	parameter int NUM_ENTRIES = 5,
	parameter int SAMPLE_BITS = 10,
	parameter int COUNT_BITS  = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [REG_IDX_BITS-1:0]          cfg_index,
	input  logic [CHAN_BITS*NUM_ENTRIES-1:0] cfg_data,
	arrs_evt_if.sink                         evt,
	arrs_res_if.source                       res
);

	`include "adc_round_robin_sequencer_macros.svh"

	ctrl_cmd_t cmd;
	dp_stat_t  stat;
	logic      evt_ready;

	assign evt.ready = evt_ready;

	arrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt.valid),
		.evt_ready (evt_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	arrs_datapath #(
		.NUM_ENTRIES (NUM_ENTRIES),
		.SAMPLE_BITS (SAMPLE_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.evt_mode        (evt.mode),
		.evt_sample      (evt.sample),
		.evt_entry_index (evt.entry_index),
		.cmd             (cmd),
		.stat            (stat),
		.res             (res)
	);

	`ARRS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, evt.valid && evt.ready, !evt.ready, "event accepted while the previous one was still executing")
	`ARRS_ASSERT_IMPLIES(a_cmp_onehot, clk, arst_n, res.valid, $onehot0({res.arm_compare_b, res.arm_compare_a}), "both timer compares armed at once")
	`ARRS_ASSERT_IMPLIES(a_no_complete, clk, arst_n, res.valid, res.sequencer_state != RS_COMPLETE, "transient complete state reported")
	`ARRS_ASSERT_IMPLIES(a_ate_pending, clk, arst_n, res.valid && res.auto_trigger_enable, res.sequencer_state == RS_PENDING, "hardware trigger enabled outside pending state")

endmodule

>>> tb/tb.sv
module tb;
	import arrs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_ENTRIES = 5;
	localparam int SAMPLE_BITS = 10;
	localparam int COUNT_BITS  = 16;
	localparam int CFG_BITS    = CHAN_BITS * NUM_ENTRIES;
	localparam int NUM_PHASES  = 12;
	localparam int PHASE_ITEMS = 152;
	localparam int HOLD_CYCLES = 64;

	// Mode code outside the defined event set; the block must ignore it.
	localparam logic [EVT_BITS-1:0] EV_NONE = 3'd7;

	localparam logic [1:0] ARM_NONE = 2'b00;
	localparam logic [1:0] ARM_A    = 2'b01;
	localparam logic [1:0] ARM_B    = 2'b10;

	typedef struct packed {
		logic [EVT_BITS-1:0]    mode;
		logic [SAMPLE_BITS-1:0] sample;
		logic [IDX_BITS-1:0]    idx;
	} evt_item_t;

	typedef struct packed {
		logic                   start_now;
		logic                   auto_trig;
		logic [TRIG_BITS-1:0]   trig_src;
		logic                   arm_a;
		logic                   arm_b;
		logic [CHAN_BITS-1:0]   chan;
		logic [STATE_BITS-1:0]  state;
		logic [IDX_BITS-1:0]    entry;
		logic [COUNT_BITS-1:0]  conv;
		logic [COUNT_BITS-1:0]  rounds;
		logic [MASK_BITS-1:0]   dmask;
		logic [SAMPLE_BITS-1:0] rval;
	} seq_status_t;

	typedef struct packed {
		logic                    is_cfg;
		logic [REG_IDX_BITS-1:0] reg_idx;
		logic [CFG_BITS-1:0]     data;
		logic [EVT_BITS-1:0]     mode;
		logic [SAMPLE_BITS-1:0]  sample;
		logic [IDX_BITS-1:0]     idx;
		logic                    pinned;
		logic [STATE_BITS-1:0]   pin_state;
		logic [SAMPLE_BITS-1:0]  pin_read;
	} plan_row_t;

	localparam int PLAN_LEN = 31;

	// Rows with pinned set carry the run state and read value expected after the event.
	plan_row_t plan [PLAN_LEN] = '{
		'{1'b0, REG_MODES, 20'h0, EV_READ,  10'h000, 3'd0, 1'b1, RS_STOPPED, 10'h000},
		'{1'b0, REG_MODES, 20'h0, EV_START, 10'h000, 3'd0, 1'b1, RS_STOPPED, 10'h000},
		'{1'b0, REG_MODES, 20'h0, EV_DONE,  10'h3FF, 3'd0, 1'b1, RS_STOPPED, 10'h000},
		'{1'b0, REG_MODES, 20'h0, EV_CMP_A, 10'h000, 3'd0, 1'b0, RS_STOPPED, 10'h000},
		'{1'b0, REG_MODES, 20'h0, EV_CMP_B, 10'h000, 3'd0, 1'b0, RS_STOPPED, 10'h000},
		'{1'b0, REG_MODES, 20'h0, EV_NONE,  10'h3FF, 3'd7, 1'b0, RS_STOPPED, 10'h000},
		'{1'b1, REG_MODES,    20'h00199, EV_NONE, 10'h0, 3'd0, 1'b0, RS_STOPPED, 10'h0},
		'{1'b1, REG_CHANNELS, 20'h3F650, EV_NONE, 10'h0, 3'd0, 1'b0, RS_STOPPED, 10'h0},
		'{1'b1, REG_TRIGGERS, 20'h05E70, EV_NONE, 10'h0, 3'd0, 1'b0, RS_STOPPED, 10'h0},
		'{1'b0, REG_MODES, 20'h0, EV_START, 10'h000, 3'd0, 1'b0, RS_STOPPED, 10'h000},
		'{1'b0, REG_MODES, 20'h0, EV_DONE,  10'h3FF, 3'd0, 1'b1, RS_PENDING, 10'h3FF},
		'{1'b0, REG_MODES, 20'h0, EV_REQ,   10'h000, 3'd1, 1'b0, RS_STOPPED, 10'h000},
		'{1'b0, REG_MODES, 20'h0, EV_REQ,   10'h000, 3'd3, 1'b0, RS_STOPPED, 10'h000},
		'{1'b0, REG_MODES, 20'h0, EV_REQ,   10'h000, 3'd7, 1'b0, RS_STOPPED, 10'h000},
		'{1'b0, REG_MODES, 20'h0, EV_DONE,  10'h000, 3'd0, 1'b1, RS_STARTED, 10'h000},
		'{1'b0, REG_MODES, 20'h0, EV_DONE,  10'h2AA, 3'd0, 1'b0, RS_STOPPED, 10'h000},
		'{1'b0, REG_MODES, 20'h0, EV_DONE,  10'h155, 3'd0, 1'b1, RS_PENDING, 10'h000},
		'{1'b0, REG_MODES, 20'h0, EV_CMP_B, 10'h000, 3'd0, 1'b0, RS_STOPPED, 10'h000},
		'{1'b0, REG_MODES, 20'h0, EV_CMP_A, 10'h000, 3'd0, 1'b0, RS_STOPPED, 10'h000},
		'{1'b0, REG_MODES, 20'h0, EV_DONE,  10'h155, 3'd0, 1'b0, RS_STOPPED, 10'h000},
		'{1'b0, REG_MODES, 20'h0, EV_DONE,  10'h0CC, 3'd0, 1'b0, RS_STOPPED, 10'h000},
		'{1'b0, REG_MODES, 20'h0, EV_CMP_B, 10'h000, 3'd0, 1'b0, RS_STOPPED, 10'h000},
		'{1'b0, REG_MODES, 20'h0, EV_DONE,  10'h001, 3'd0, 1'b0, RS_STOPPED, 10'h000},
		'{1'b0, REG_MODES, 20'h0, EV_READ,  10'h000, 3'd7, 1'b1, RS_PENDING, 10'h000},
		'{1'b0, REG_MODES, 20'h0, EV_READ,  10'h000, 3'd1, 1'b1, RS_PENDING, 10'h155},
		'{1'b0, REG_MODES, 20'h0, EV_STOP,  10'h000, 3'd0, 1'b1, RS_STOPPED, 10'h000},
		'{1'b0, REG_MODES, 20'h0, EV_READ,  10'h000, 3'd2, 1'b1, RS_STOPPED, 10'h0CC},
		'{1'b1, REG_MODES,    20'h003FF, EV_NONE, 10'h0, 3'd0, 1'b0, RS_STOPPED, 10'h0},
		'{1'b1, REG_CHANNELS, 20'hFFFFF, EV_NONE, 10'h0, 3'd0, 1'b0, RS_STOPPED, 10'h0},
		'{1'b1, REG_TRIGGERS, 20'h07FFF, EV_NONE, 10'h0, 3'd0, 1'b0, RS_STOPPED, 10'h0},
		'{1'b0, REG_MODES, 20'h0, EV_START, 10'h000, 3'd0, 1'b1, RS_STOPPED, 10'h000}
	};

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_we;
	logic [REG_IDX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0]     cfg_data;

	arrs_evt_if #(.SAMPLE_BITS(SAMPLE_BITS)) evt_ch ();
	arrs_res_if #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS)) res_ch ();

	adc_round_robin_sequencer #(
		.NUM_ENTRIES(NUM_ENTRIES),
		.SAMPLE_BITS(SAMPLE_BITS),
		.COUNT_BITS(COUNT_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.evt(evt_ch),
		.res(res_ch)
	);

	// Shadow of the sequencer: configuration and state after every accepted event.
	logic [MODE_BITS*NUM_ENTRIES-1:0] cfg_modes = '0;
	logic [CFG_BITS-1:0]              cfg_chans = '0;
	logic [TRIG_BITS*NUM_ENTRIES-1:0] cfg_trigs = '0;
	logic [IDX_BITS-1:0]              sched_pos = '0;
	logic [STATE_BITS-1:0]            run_st = RS_STOPPED;
	logic [NUM_ENTRIES-1:0]           oneshot_req = '0;
	logic [SAMPLE_BITS-1:0]           sample_mem [NUM_ENTRIES] = '{default: '0};
	logic [COUNT_BITS-1:0]            conv_cnt = '0;
	logic [COUNT_BITS-1:0]            round_cnt = '0;
	logic [1:0]                       cmp_arm = ARM_NONE;
	logic [MASK_BITS-1:0]             pin_mask = '0;

	seq_status_t expected_status [$];

	int  n_events = 0;
	int  n_checked = 0;
	int  n_errors = 0;
	int  n_conv = 0;
	int  n_starts = 0;
	int  n_writes = 0;
	int  burst_left = 0;
	bit  hold_off_req = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [MODE_BITS-1:0] mode_at(input int i);
		return cfg_modes[MODE_BITS*i +: MODE_BITS];
	endfunction

	function automatic logic [CHAN_BITS-1:0] chan_at(input int i);
		return cfg_chans[CHAN_BITS*i +: CHAN_BITS];
	endfunction

	function automatic logic [TRIG_BITS-1:0] trig_at(input int i);
		return cfg_trigs[TRIG_BITS*i +: TRIG_BITS];
	endfunction

	// Prepares the entry at the schedule position; true when it converts at once.
	function automatic bit arm_entry();
		logic [TRIG_BITS-1:0] t;
		t = trig_at(int'(sched_pos));
		cmp_arm = ARM_NONE;
		if (t == TRIG_IMMEDIATE) begin
			run_st = RS_STARTED;
			return 1'b1;
		end
		run_st = RS_PENDING;
		if (t == TRIG_CMP_A)
			cmp_arm = ARM_A;
		else if (t == TRIG_CMP_B)
			cmp_arm = ARM_B;
		return 1'b0;
	endfunction

	// Rotating search for the next eligible entry, counting a round on each wrap.
	function automatic bit advance_schedule();
		logic [IDX_BITS-1:0]  origin;
		logic [IDX_BITS-1:0]  p;
		logic [MODE_BITS-1:0] m;
		origin = sched_pos;
		for (int k = 0; k < NUM_ENTRIES; k++) begin
			p = sched_pos + 3'd1;
			if (int'(p) >= NUM_ENTRIES) begin
				p = '0;
				round_cnt++;
			end
			sched_pos = p;
			m = mode_at(int'(p));
			if (m == MODE_CONT || (m == MODE_ONESHOT && oneshot_req[p]))
				return arm_entry();
			if (p == origin)
				break;
		end
		run_st = RS_STOPPED;
		return 1'b0;
	endfunction

	function automatic seq_status_t sequence_event(input evt_item_t e);
		seq_status_t          s;
		logic                 pulse;
		logic [SAMPLE_BITS-1:0] rv;
		logic [CHAN_BITS-1:0] c;
		logic [TRIG_BITS-1:0] t;
		pulse = 1'b0;
		rv = '0;
		case (e.mode)
			EV_START: begin
				n_starts++;
				conv_cnt = '0;
				round_cnt = '0;
				cmp_arm = ARM_NONE;
				pin_mask = '0;
				for (int i = 0; i < NUM_ENTRIES; i++) begin
					c = chan_at(i);
					if (int'(c) <= MAX_DIGITAL_PIN)
						pin_mask[c[2:0]] = 1'b1;
				end
				pulse = advance_schedule();
			end
			EV_STOP: begin
				run_st = RS_STOPPED;
				cmp_arm = ARM_NONE;
			end
			EV_DONE: begin
				if (run_st == RS_STARTED || (run_st == RS_PENDING && cmp_arm == ARM_NONE)) begin
					n_conv++;
					run_st = RS_COMPLETE;
					conv_cnt++;
					sample_mem[sched_pos] = e.sample;
					oneshot_req[sched_pos] = 1'b0;
					rv = e.sample;
					pulse = advance_schedule();
				end
			end
			EV_CMP_A, EV_CMP_B: begin
				if ((e.mode == EV_CMP_A) ? cmp_arm[0] : cmp_arm[1]) begin
					cmp_arm = ARM_NONE;
					run_st = RS_STARTED;
					pulse = 1'b1;
				end
			end
			EV_REQ: begin
				if (int'(e.idx) < NUM_ENTRIES)
					oneshot_req[e.idx] = 1'b1;
			end
			EV_READ: begin
				if (int'(e.idx) < NUM_ENTRIES)
					rv = sample_mem[e.idx];
			end
			default: ;
		endcase
		t = trig_at(int'(sched_pos));
		s.start_now = pulse;
		s.auto_trig = (run_st == RS_PENDING && t >= TRIG_HW_FIRST && t <= TRIG_HW_LAST);
		s.trig_src = s.auto_trig ? t - 3'd1 : '0;
		s.arm_a = cmp_arm[0];
		s.arm_b = cmp_arm[1];
		s.chan = chan_at(int'(sched_pos));
		s.state = run_st;
		s.entry = sched_pos;
		s.conv = conv_cnt;
		s.rounds = round_cnt;
		s.dmask = pin_mask;
		s.rval = rv;
		return s;
	endfunction

	// Mostly events that move the scan along from its current state, plus some noise.
	function automatic evt_item_t next_event();
		evt_item_t e;
		int        r;
		r = $urandom_range(0, 99);
		e.sample = SAMPLE_BITS'($urandom_range(0, 1023));
		e.idx = IDX_BITS'($urandom_range(0, 7));
		if (r < 8)
			e.mode = EVT_BITS'($urandom_range(0, 7));
		else if (r < 14) begin
			e.mode = EV_REQ;
			e.idx = IDX_BITS'($urandom_range(0, NUM_ENTRIES - 1));
		end else if (r < 18) begin
			e.mode = EV_READ;
			e.idx = IDX_BITS'($urandom_range(0, NUM_ENTRIES - 1));
		end else if (r < 20)
			e.mode = EV_STOP;
		else if (r < 22)
			e.mode = EV_START;
		else begin
			case (run_st)
				RS_STARTED: e.mode = EV_DONE;
				RS_PENDING: begin
					if (cmp_arm[0])
						e.mode = EV_CMP_A;
					else if (cmp_arm[1])
						e.mode = EV_CMP_B;
					else
						e.mode = EV_DONE;
				end
				default: e.mode = EV_START;
			endcase
		end
		return e;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			n_errors++;
		end
	endtask

	task automatic compare_status(input seq_status_t want);
		check_field("start_now", 32'(want.start_now), 32'(res_ch.start_now));
		check_field("auto_trigger_enable", 32'(want.auto_trig),
			32'(res_ch.auto_trigger_enable));
		check_field("trigger_source", 32'(want.trig_src), 32'(res_ch.trigger_source));
		check_field("arm_compare_a", 32'(want.arm_a), 32'(res_ch.arm_compare_a));
		check_field("arm_compare_b", 32'(want.arm_b), 32'(res_ch.arm_compare_b));
		check_field("channel_select", 32'(want.chan), 32'(res_ch.channel_select));
		check_field("sequencer_state", 32'(want.state), 32'(res_ch.sequencer_state));
		check_field("current_entry", 32'(want.entry), 32'(res_ch.current_entry));
		check_field("conversions_done", 32'(want.conv), 32'(res_ch.conversions_done));
		check_field("rounds_done", 32'(want.rounds), 32'(res_ch.rounds_done));
		check_field("digital_disable_mask", 32'(want.dmask),
			32'(res_ch.digital_disable_mask));
		check_field("read_value", 32'(want.rval), 32'(res_ch.read_value));
		n_checked++;
	endtask

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_status.size() == 0) begin
				$display("%0t: result transaction with nothing expected", $time);
				n_errors++;
			end else
				compare_status(expected_status.pop_front());
		end
	end

	// Receiver: segments of different stall patterns, plus a long hold-off on request.
	initial begin
		int seg_left;
		int style;
		int hold_left;
		seg_left = 0;
		style = 0;
		hold_left = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (seg_left == 0) begin
				seg_left = $urandom_range(4, 40);
				style = $urandom_range(0, 3);
			end
			seg_left--;
			if (hold_left != 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				case (style)
					0: res_ch.ready <= 1'b1;
					1: res_ch.ready <= ($urandom_range(0, 1) == 0);
					2: res_ch.ready <= ($urandom_range(0, 3) == 0);
					default: res_ch.ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// All tasks below are entered and left at a falling edge.
	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				evt_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic drive_item(input evt_item_t e, input logic pinned,
			input logic [STATE_BITS-1:0] pin_state, input logic [SAMPLE_BITS-1:0] pin_read);
		seq_status_t want;
		evt_ch.valid <= 1'b1;
		evt_ch.mode <= e.mode;
		evt_ch.sample <= e.sample;
		evt_ch.entry_index <= e.idx;
		@(posedge clk);
		while (!evt_ch.ready) @(posedge clk);
		want = sequence_event(e);
		if (pinned) begin
			want.state = pin_state;
			want.rval = pin_read;
		end
		expected_status.push_back(want);
		n_events++;
		@(negedge clk);
	endtask

	// Lets every outstanding result drain so the block is idle.
	task automatic quiesce();
		evt_ch.valid <= 1'b0;
		while (expected_status.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Leaves cfg_we high; the caller lowers it after the last write of a group.
	task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_MODES:    cfg_modes = data[MODE_BITS*NUM_ENTRIES-1:0];
			REG_CHANNELS: cfg_chans = data;
			REG_TRIGGERS: cfg_trigs = data[TRIG_BITS*NUM_ENTRIES-1:0];
			default: ;
		endcase
		n_writes++;
		@(negedge clk);
	endtask

	task automatic run_plan();
		evt_item_t cur;
		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				if (!cfg_we)
					quiesce();
				write_reg(plan[i].reg_idx, plan[i].data);
			end else begin
				if (cfg_we)
					cfg_we <= 1'b0;
				cur.mode = plan[i].mode;
				cur.sample = plan[i].sample;
				cur.idx = plan[i].idx;
				pace_sender();
				drive_item(cur, plan[i].pinned, plan[i].pin_state, plan[i].pin_read);
			end
		end
	endtask

	task automatic run_random();
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			quiesce();
			write_reg(REG_MODES, (ph == 0) ? 20'h00155 : (ph == 1) ? 20'h002AA :
				CFG_BITS'($urandom));
			write_reg(REG_CHANNELS, (ph == 1) ? 20'h00000 : (ph == 2) ? 20'hFFFFF :
				CFG_BITS'($urandom));
			write_reg(REG_TRIGGERS, (ph == 0) ? 20'h00000 : (ph == 1) ? 20'h07FFF :
				CFG_BITS'($urandom));
			cfg_we <= 1'b0;
			if (ph == 3 || ph == 8)
				hold_off_req = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pace_sender();
				drive_item(next_event(), 1'b0, RS_STOPPED, '0);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_MODES;
		cfg_data = '0;
		evt_ch.valid = 1'b0;
		evt_ch.mode = EV_START;
		evt_ch.sample = '0;
		evt_ch.entry_index = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		run_plan();
		run_random();
		quiesce();
		$display("Drove %0d events through %0d register writes; %0d scan starts, %0d conversions.",
			n_events, n_writes, n_starts, n_conv);
		$display("Compared %0d result transactions, %0d field mismatches.", n_checked, n_errors);
		if (n_errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
